FILE: rtl/sha256_stream_hasher_defines.svh
// Assertion macros shared by the hasher checker.
// No dependencies.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: rtl/sha_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;
   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam hash_type INIT_H = '{32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                                  32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type [0:63] ROUND_K = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam int QUEUE_DEPTH = 2;

   // Classified command handed from front to back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       end_of_message;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_ROUND, ST_EMIT
   } back_state_type;

   function automatic word_type ror32(word_type v, int n);
      ror32 = (v >> n) | (v << (32 - n));
   endfunction
endpackage

FILE: rtl/sha_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
interface sha_if #(parameter int WIDTH = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher: a two-word queue feeds the back end, which takes a byte a
// cycle while idle and holds the input off while it compresses each full block.
// Padding shifts in a byte a cycle: the digest takes one padding block when the last
// block holds n (up to 55) bytes and a second block otherwise; then the four 64-bit
// digest parts, two hash words each, leave one per accepted cycle.
// Synchronous active-high reset restores the initial hash and empties the queue.
module sha256_stream_hasher (
   input  logic clock,
   input  logic reset,
   sha_if.sink   req,
   sha_if.source rsp
);
   sha_pkg::cmd_type req_cmd, q_cmd;
   logic q_valid, q_ready;
   logic [63:0] rsp_part;
   logic [1:0]  rsp_index;
   logic        rsp_last;

   assign req_cmd = sha_pkg::cmd_type'(req.payload);
   assign rsp.payload = {rsp_part, rsp_index, rsp_last};

   sha_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_cmd(req_cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

   sha_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_part(rsp_part), .out_index(rsp_index), .out_last(rsp_last));
endmodule

FILE: rtl/sha_front.sv
// Front end: accepts request words, drops empty ones, queues commands.
// Depends on sha_pkg.
module sha_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sha_pkg::cmd_type        in_cmd,
   output logic                    q_valid,
   input  logic                    q_ready,
   output sha_pkg::cmd_type        q_cmd
);
   sha_pkg::cmd_type [sha_pkg::QUEUE_DEPTH-1:0] slot_ff;
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'(sha_pkg::QUEUE_DEPTH));
   assign push = in_valid && in_ready && (in_cmd.has_data || in_cmd.end_of_message);
   assign q_valid = (count_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cmd = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      rd_in = pop ? ~rd_ff : rd_ff;
      wr_in = push ? ~wr_ff : wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) slot_ff[wr_ff] <= in_cmd;
   end
endmodule

FILE: rtl/sha_back.sv
// Back end: byte shift into the message schedule, padding, 64-round compression
// and digest output. Depends on sha_pkg.
module sha_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  sha_pkg::cmd_type  q_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_part,
   output logic [1:0]        out_index,
   output logic              out_last
);
   sha_pkg::back_state_type state_ff, state_in;
   sha_pkg::hash_type hash_ff, hash_in;
   sha_pkg::word_type [15:0] w_ff, w_in, w_byte;
   sha_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   sha_pkg::word_type a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic        pend_ff, pend_in;
   logic        mark_ff, mark_in;
   logic        spill_ff, spill_in;
   logic        pad_ff, pad_in;
   logic [1:0]  part_ff, part_in;
   logic [7:0]  shift_byte;
   sha_pkg::word_type t1, t2, s0, s1, wn;

   always_comb begin
      t1 = h_ff + (sha_pkg::ror32(e_ff, 6) ^ sha_pkg::ror32(e_ff, 11) ^ sha_pkg::ror32(e_ff, 25))
         + ((e_ff & f_ff) ^ (~e_ff & g_ff)) + sha_pkg::ROUND_K[round_ff] + w_ff[0];
      t2 = (sha_pkg::ror32(a_ff, 2) ^ sha_pkg::ror32(a_ff, 13) ^ sha_pkg::ror32(a_ff, 22))
         + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      s0 = sha_pkg::ror32(w_ff[1], 7) ^ sha_pkg::ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::ror32(w_ff[14], 17) ^ sha_pkg::ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // shift one byte into the newest schedule word, advancing the words at each word start
   always_comb begin
      shift_byte = q_cmd.data_byte;
      if (state_ff == sha_pkg::ST_PAD) begin
         if (mark_ff) shift_byte = 8'h80;
         else if (fill_ff >= 6'd56 && !spill_ff) shift_byte = len_ff[63 - 8*fill_ff[2:0] -: 8];
         else shift_byte = 8'h00;
      end
      for (int i = 0; i < 15; i++) w_byte[i] = (fill_ff[1:0] == 2'd0) ? w_ff[i+1] : w_ff[i];
      w_byte[15] = {w_ff[15][23:0], shift_byte};
   end

   assign q_ready = (state_ff == sha_pkg::ST_IDLE);
   assign out_valid = (state_ff == sha_pkg::ST_EMIT);
   assign out_part = {hash_ff[{part_ff, 1'b0}], hash_ff[{part_ff, 1'b1}]};
   assign out_index = part_ff;
   assign out_last = (part_ff == 2'd3);

   always_comb begin
      state_in = state_ff; hash_in = hash_ff; w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      e_in = e_ff; f_in = f_ff; g_in = g_ff; h_in = h_ff;
      fill_in = fill_ff; len_in = len_ff; round_in = round_ff; part_in = part_ff;
      pend_in = pend_ff; mark_in = mark_ff; spill_in = spill_ff; pad_in = pad_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_cmd.has_data) begin
                  w_in = w_byte;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
                        {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                         hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
                     len_in = len_ff + 64'd512;
                     pend_in = q_cmd.end_of_message;
                     round_in = 6'd0;
                     state_in = sha_pkg::ST_ROUND;
                  end else if (q_cmd.end_of_message) begin
                     mark_in = 1'b1;
                     state_in = sha_pkg::ST_PAD;
                  end
               end else if (q_cmd.end_of_message) begin
                  mark_in = 1'b1;
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            w_in = w_byte;
            fill_in = fill_ff + 6'd1;
            if (mark_ff) begin
               mark_in = 1'b0;
               spill_in = (fill_ff >= 6'd56);
               len_in = len_ff + {55'd0, fill_ff, 3'd0};
            end
            if (fill_ff == 6'd63) begin
               {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
                  {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                   hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
               pad_in = 1'b1;
               round_in = 6'd0;
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            h_in = g_ff; g_in = f_ff; f_in = e_ff; e_in = d_ff + t1;
            d_in = c_ff; c_in = b_ff; b_in = a_ff; a_in = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = wn;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               hash_in[0] = hash_ff[0] + a_in; hash_in[1] = hash_ff[1] + b_in;
               hash_in[2] = hash_ff[2] + c_in; hash_in[3] = hash_ff[3] + d_in;
               hash_in[4] = hash_ff[4] + e_in; hash_in[5] = hash_ff[5] + f_in;
               hash_in[6] = hash_ff[6] + g_in; hash_in[7] = hash_ff[7] + h_in;
               if (pend_ff) begin
                  pend_in = 1'b0;
                  mark_in = 1'b1;
                  state_in = sha_pkg::ST_PAD;
               end else if (spill_ff) begin
                  spill_in = 1'b0;
                  state_in = sha_pkg::ST_PAD;
               end else if (pad_ff) begin
                  part_in = 2'd0;
                  state_in = sha_pkg::ST_EMIT;
               end else begin
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         sha_pkg::ST_EMIT: begin
            if (out_ready) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  hash_in = sha_pkg::INIT_H;
                  len_in = 64'd0;
                  fill_in = 6'd0;
                  part_in = 2'd0;
                  pad_in = 1'b0;
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         hash_ff <= sha_pkg::INIT_H;
         fill_ff <= 6'd0;
         len_ff <= 64'd0;
         part_ff <= 2'd0;
         round_ff <= 6'd0;
         pend_ff <= 1'b0;
         mark_ff <= 1'b0;
         spill_ff <= 1'b0;
         pad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         part_ff <= part_in;
         round_ff <= round_in;
         pend_ff <= pend_in;
         mark_ff <= mark_in;
         spill_ff <= spill_in;
         pad_ff <= pad_in;
      end
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      e_ff <= e_in; f_ff <= f_in; g_ff <= g_in; h_ff <= h_in;
   end
endmodule

FILE: rtl/sha_checker.sv
// Port checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_defines.svh.
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [66:0] rsp_payload
);
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `SHA_ASSERT_IMPL(a_last, clock, reset, rsp_valid, rsp_payload[0] == (rsp_payload[2:1] == 2'd3))
   `SHA_ASSERT_NEXT(a_next, clock, reset, rsp_valid && rsp_ready && !rsp_payload[0], rsp_valid && rsp_payload[2:1] == $past(rsp_payload[2:1]) + 2'd1)
endmodule

bind sha256_stream_hasher sha_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
